@@ rtl/g4c_pkg.sv @@
// ----------------------------------------------------------------------------
// g4c_pkg
// Shared types, constants and pixel functions for the gray frame compositor.
// ----------------------------------------------------------------------------
package g4c_pkg;

  localparam int FRAME_ROWS_DEF = 64;
  localparam int SRC_COLS_DEF   = 32;
  localparam int WORD_W         = 32;
  localparam int ROW_W          = 6;
  localparam int SCOL_W         = 5;
  localparam int RCOL_W         = 7;
  localparam int LEVEL_W        = 4;

  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_COMPOSITE = 2'd1,
    CMD_READ      = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    BSEL_B0 = 2'd0,
    BSEL_B1 = 2'd1,
    BSEL_B2 = 2'd2,
    BSEL_B3 = 2'd3
  } bsel_t;

  // Each set source bit writes the level into its nibble, or the larger of
  // the old nibble and the level in max mode. Bit 7 maps to bits 31..28.
  function automatic logic [WORD_W-1:0] blend_word(input logic [WORD_W-1:0] word,
                                                   input logic [7:0] bits,
                                                   input logic [LEVEL_W-1:0] lvl,
                                                   input logic use_max);
    logic [WORD_W-1:0]  res;
    logic [LEVEL_W-1:0] old;
    res = word;
    for (int i = 0; i < 8; i++) begin
      old = word[28-4*i +: 4];
      if (bits[7-i]) begin
        res[28-4*i +: 4] = (use_max && (old > lvl)) ? old : lvl;
      end
    end
    return res;
  endfunction

  // Frame byte 0 of a word sits in bits 31..24.
  function automatic logic [7:0] pick_byte(input logic [WORD_W-1:0] word,
                                           input logic [1:0] bsel);
    logic [7:0] res;
    unique case (bsel)
      BSEL_B0: res = word[31:24];
      BSEL_B1: res = word[23:16];
      BSEL_B2: res = word[15:8];
      BSEL_B3: res = word[7:0];
      default: res = word[31:24];
    endcase
    return res;
  endfunction

endpackage

@@ rtl/g4c_frame_mem.sv @@
// ----------------------------------------------------------------------------
// g4c_frame_mem
// Frame store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module g4c_frame_mem #(
  parameter int DEPTH  = g4c_pkg::FRAME_ROWS_DEF * g4c_pkg::SRC_COLS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [g4c_pkg::WORD_W-1:0]  wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [g4c_pkg::WORD_W-1:0]  rdata
);

  logic [g4c_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/g4c_sweep.sv @@
// ----------------------------------------------------------------------------
// g4c_sweep
// Fill sequencer: writes one fill word per cycle across the whole store.
// ----------------------------------------------------------------------------
module g4c_sweep #(
  parameter int DEPTH  = g4c_pkg::FRAME_ROWS_DEF * g4c_pkg::SRC_COLS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [g4c_pkg::WORD_W-1:0]  fill_in,
  output logic                        busy,
  output logic [ADDR_W-1:0]           addr,
  output logic [g4c_pkg::WORD_W-1:0]  data
);

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  logic [g4c_pkg::WORD_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
      fill <= '0;
    end else if (start) begin
      busy <= 1'b1;
      addr <= '0;
      fill <= fill_in;
    end else if (busy) begin
      if (addr == LAST) begin
        busy <= 1'b0;
      end
      addr <= addr + 1'b1;
    end
  end

  assign data = fill;

endmodule

@@ rtl/mono_to_gray4_compositor.sv @@
// ----------------------------------------------------------------------------
// mono_to_gray4_compositor
// Monochrome-to-gray compositor over a 4-bit-per-pixel frame store.
// ----------------------------------------------------------------------------
// The command is registered in the s1 stage, and res_valid is registered when s1 advances.
// Composite and read commands are accepted back to back while the result is not
// stalled, due to the single read-modify-write of the frame memory with write-back forwarding.
// After a clear, commands are held off until the sweep has written every word of the
// store; the sweep writes one word per cycle.
// Reset runs the same sweep with level zero and holds commands off until it is done.
module mono_to_gray4_compositor #(
  parameter int FRAME_ROWS = g4c_pkg::FRAME_ROWS_DEF,
  parameter int SRC_COLS   = g4c_pkg::SRC_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [1:0]                    command,
  input  logic [g4c_pkg::ROW_W-1:0]     row,
  input  logic [g4c_pkg::SCOL_W-1:0]    src_byte_col,
  input  logic [7:0]                    src_bits,
  input  logic [g4c_pkg::LEVEL_W-1:0]   level,
  input  logic                          blend_max,
  input  logic [g4c_pkg::RCOL_W-1:0]    read_col,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [7:0]                    frame_byte
);

  localparam int DEPTH  = FRAME_ROWS * SRC_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SC_W   = $clog2(SRC_COLS + 1);
  localparam int IDX_W  = (ADDR_W > g4c_pkg::ROW_W + SC_W) ? ADDR_W
                                                           : g4c_pkg::ROW_W + SC_W + 1;

  logic                         cmd_acc;
  logic                         row_ok;
  logic                         scol_ok;
  logic                         rcol_ok;
  logic                         op_ok;
  logic [g4c_pkg::SCOL_W-1:0]   word_col;
  logic [IDX_W-1:0]             idx_full;

  logic                         s1_valid;
  logic [1:0]                   s1_cmd;
  logic [ADDR_W-1:0]            s1_addr;
  logic                         s1_ok;
  logic [7:0]                   s1_bits;
  logic [g4c_pkg::LEVEL_W-1:0]  s1_level;
  logic                         s1_max;
  logic [1:0]                   s1_bsel;
  logic                         s1_adv;

  logic [g4c_pkg::WORD_W-1:0]   rdata;
  logic [g4c_pkg::WORD_W-1:0]   old_word;
  logic [g4c_pkg::WORD_W-1:0]   new_word;
  logic [7:0]                   result;
  logic                         wb_en;
  logic                         clear_start;

  logic                         fwd_valid;
  logic [ADDR_W-1:0]            fwd_addr;
  logic [g4c_pkg::WORD_W-1:0]   fwd_data;

  logic                         sweep_busy;
  logic [ADDR_W-1:0]            sweep_addr;
  logic [g4c_pkg::WORD_W-1:0]   sweep_data;

  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [g4c_pkg::WORD_W-1:0]   mem_wdata;

  // Command decode and address calculation.
  always_comb begin
    row_ok   = 32'(row) < 32'(FRAME_ROWS);
    scol_ok  = 32'(src_byte_col) < 32'(SRC_COLS);
    rcol_ok  = 32'(read_col) < 32'(4 * SRC_COLS);
    word_col = (command == g4c_pkg::CMD_READ) ? read_col[g4c_pkg::RCOL_W-1:2] : src_byte_col;
    idx_full = IDX_W'(row) * IDX_W'(SRC_COLS) + IDX_W'(word_col);
    unique case (command)
      g4c_pkg::CMD_COMPOSITE: op_ok = row_ok && scol_ok && (src_bits != 8'd0);
      g4c_pkg::CMD_READ:      op_ok = row_ok && rcol_ok;
      default:                op_ok = 1'b0;
    endcase
  end

  assign s1_adv    = s1_valid && (!res_valid || !res_stall);
  assign cmd_stall = sweep_busy ||
                     (s1_valid && ((s1_cmd == g4c_pkg::CMD_CLEAR) || !s1_adv));
  assign cmd_acc   = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      s1_cmd   <= command;
      s1_addr  <= idx_full[ADDR_W-1:0];
      s1_ok    <= op_ok;
      s1_bits  <= src_bits;
      s1_level <= level;
      s1_max   <= blend_max;
      s1_bsel  <= read_col[1:0];
    end
  end

  // Read-modify-write stage. The word written in the previous transfer is
  // forwarded, since the memory read of this command returns the old value.
  always_comb begin
    old_word    = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rdata;
    new_word    = g4c_pkg::blend_word(old_word, s1_bits, s1_level, s1_max);
    wb_en       = s1_adv && (s1_cmd == g4c_pkg::CMD_COMPOSITE) && s1_ok;
    clear_start = s1_adv && (s1_cmd == g4c_pkg::CMD_CLEAR);
    result      = (s1_ok && (s1_cmd == g4c_pkg::CMD_READ)) ?
                  g4c_pkg::pick_byte(old_word, s1_bsel) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || sweep_busy) begin
      fwd_valid <= 1'b0;
    end else if (wb_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      fwd_addr <= s1_addr;
      fwd_data <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      frame_byte <= result;
    end
  end

  assign mem_we    = sweep_busy || wb_en;
  assign mem_waddr = sweep_busy ? sweep_addr : s1_addr;
  assign mem_wdata = sweep_busy ? sweep_data : new_word;

  g4c_sweep #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .start   (clear_start),
    .fill_in ({8{s1_level}}),
    .busy    (sweep_busy),
    .addr    (sweep_addr),
    .data    (sweep_data)
  );

  g4c_frame_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (cmd_acc),
    .raddr (idx_full[ADDR_W-1:0]),
    .rdata (rdata)
  );

endmodule
